@@ hw/rtl/ray_triangle_intersection_core_macros.svh @@
// assertion helpers shared by the core
`ifndef RAY_TRIANGLE_INTERSECTION_CORE_MACROS_SVH
`define RAY_TRIANGLE_INTERSECTION_CORE_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define RTI_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define RTI_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rti_pkg.sv @@
package rti_pkg;

    localparam int COORD_W    = 32;
    localparam int DIR_W      = 18;
    localparam int TOL_W      = 16;
    localparam int EDGE_W     = 33;
    localparam int NRM_W      = 67;
    localparam int DOT_W      = 68;
    localparam int A_W        = 102;
    localparam int B_W        = 87;
    localparam int NEGA_W     = 103;
    localparam int NUM_W      = 121;
    localparam int QUO_W      = 34;
    localparam int DIVN_W     = 122;
    localparam int DIVD_W     = 88;
    localparam int QUAD_W     = 137;
    localparam int SUM_W      = 36;
    localparam int MUL_CW     = 34;
    localparam int PIPE_DEPTH = 53;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd6;

    localparam logic [1:0] ST_MISS       = 2'd0;
    localparam logic [1:0] ST_HIT        = 2'd1;
    localparam logic [1:0] ST_IN_PLANE   = 2'd2;
    localparam logic [1:0] ST_DEGENERATE = 2'd3;

    localparam logic signed [SUM_W-1:0] P_MAX = 36'sd2147483647;
    localparam logic signed [SUM_W-1:0] P_MIN = -36'sd2147483648;

    typedef struct packed {
        logic deg;
        logic par;
        logic behind;
        logic azero;
    } rti_flags_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [COORD_W-1:0]  point_z;
        logic signed [COORD_W-1:0]  point_y;
        logic signed [COORD_W-1:0]  point_x;
    } rti_result_t;

endpackage

@@ hw/rtl/rti_delay.sv @@
module rti_delay import rti_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         ce,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] sr_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (ce) begin
            sr_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign q = sr_reg[DEPTH-1];

endmodule

@@ hw/rtl/rti_mul.sv @@
module rti_mul import rti_pkg::*; #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                    aclk,
    input  logic                    ce,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int NA  = (AW + MUL_CW - 1) / MUL_CW;
    localparam int NB  = (BW + MUL_CW - 1) / MUL_CW;
    localparam int PW  = AW + BW;
    localparam int PPW = 2 * MUL_CW + 2;

    logic signed [NA*MUL_CW-1:0] a_ext;
    logic signed [NB*MUL_CW-1:0] b_ext;
    logic signed [MUL_CW:0]      a_part [NA];
    logic signed [MUL_CW:0]      b_part [NB];
    logic signed [PPW-1:0]       pp_reg [NA][NB];
    logic signed [PW-1:0]        term;
    logic signed [PW-1:0]        acc;
    logic signed [PW-1:0]        p_reg;

    assign a_ext = (NA*MUL_CW)'(a);
    assign b_ext = (NB*MUL_CW)'(b);

    // low chunks are unsigned, only the top chunk carries the sign
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            if (i == NA - 1) begin
                a_part[i] = {a_ext[NA*MUL_CW-1], a_ext[i*MUL_CW +: MUL_CW]};
            end else begin
                a_part[i] = {1'b0, a_ext[i*MUL_CW +: MUL_CW]};
            end
        end
        for (int j = 0; j < NB; j++) begin
            if (j == NB - 1) begin
                b_part[j] = {b_ext[NB*MUL_CW-1], b_ext[j*MUL_CW +: MUL_CW]};
            end else begin
                b_part[j] = {1'b0, b_ext[j*MUL_CW +: MUL_CW]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= a_part[i] * b_part[j];
                end
            end
        end
    end

    always_comb begin
        acc  = '0;
        term = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                term = PW'(pp_reg[i][j]);
                term = term << ((i + j) * MUL_CW);
                acc  = acc + term;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_reg <= acc;
        end
    end

    assign p = p_reg;

endmodule

@@ hw/rtl/rti_div.sv @@
module rti_div import rti_pkg::*; #(
    parameter int NW = 122,
    parameter int DW = 88,
    parameter int QB = 34
) (
    input  logic          aclk,
    input  logic          ce,
    input  logic [NW-1:0] n,
    input  logic [DW-1:0] d,
    output logic [QB-1:0] q
);

    // restoring division, one quotient bit per stage, msb first
    logic [NW-1:0] rem_reg [QB-1];
    logic [DW-1:0] d_reg   [QB-1];
    logic [QB-1:0] q_reg   [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [NW-1:0] rem_in;
        logic [NW-1:0] sub;
        logic [DW-1:0] d_in;
        logic [QB-1:0] q_in;
        logic [QB-1:0] q_nx;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in = n;
            assign d_in   = d;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign d_in   = d_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        always_comb begin
            sub  = NW'(d_in) << (QB - 1 - k);
            take = (rem_in >= sub);
            q_nx = q_in;
            q_nx[QB-1-k] = take;
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                q_reg[k] <= q_nx;
            end
        end

        if (k < QB - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[k] <= take ? (rem_in - sub) : rem_in;
                    d_reg[k]   <= d_in;
                end
            end
        end
    end

    assign q = q_reg[QB-1];

endmodule

@@ hw/rtl/rti_skid.sv @@
module rti_skid import rti_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  rti_result_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output rti_result_t out_item
);

    logic        out_valid_reg;
    logic        skid_valid_reg;
    rti_result_t out_item_reg;
    rti_result_t skid_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_item_reg   <= skid_item_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
                out_item_reg  <= in_item;
            end
        end else if (in_valid && !skid_valid_reg) begin
            // output is held, park the transfer
            skid_valid_reg <= 1'b1;
            skid_item_reg  <= in_item;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ hw/rtl/ray_triangle_intersection_core.sv @@
// throughput: one triangle per cycle while the output is not stalled, set by the fully pipelined datapath
// (the 34-stage divider and the split multipliers each take a new item every cycle)
// a full output and skid register stall the whole pipeline until m_tready
// aresetn is synchronous, active low: clears valid state and loads register defaults
`include "ray_triangle_intersection_core_macros.svh"

module ray_triangle_intersection_core import rti_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [287:0]          s_tdata,   // v1_x v1_y v1_z v2_x v2_y v2_z v3_x v3_y v3_z
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [95:0]           m_tdata,   // point_x point_y point_z
    output logic [1:0]            m_tuser    // status
);

    logic signed [COORD_W-1:0] org_reg [3];
    logic signed [DIR_W-1:0]   dir_reg [3];
    logic [TOL_W-1:0]          tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= 18'sd65536;
            dir_reg[1] <= '0;
            dir_reg[2] <= '0;
            tol_reg    <= 16'd1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ORIGIN_X:  org_reg[0] <= cfg_wr_data;
                CFG_ORIGIN_Y:  org_reg[1] <= cfg_wr_data;
                CFG_ORIGIN_Z:  org_reg[2] <= cfg_wr_data;
                CFG_DIR_X:     dir_reg[0] <= cfg_wr_data[DIR_W-1:0];
                CFG_DIR_Y:     dir_reg[1] <= cfg_wr_data[DIR_W-1:0];
                CFG_DIR_Z:     dir_reg[2] <= cfg_wr_data[DIR_W-1:0];
                CFG_TOLERANCE: tol_reg    <= cfg_wr_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    logic                  pipe_ce;
    logic [PIPE_DEPTH-1:0] vld_reg;

    assign s_tready = pipe_ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_ce) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // stage 1: edges and origin offset
    logic signed [COORD_W-1:0] vtx [9];
    logic signed [EDGE_W-1:0]  s1_u_reg  [3];
    logic signed [EDGE_W-1:0]  s1_v_reg  [3];
    logic signed [EDGE_W-1:0]  s1_w0_reg [3];
    logic signed [COORD_W-1:0] s1_p1_reg [3];

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            vtx[i] = s_tdata[i*COORD_W +: COORD_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            for (int i = 0; i < 3; i++) begin
                s1_u_reg[i]  <= EDGE_W'(vtx[3+i]) - EDGE_W'(vtx[i]);
                s1_v_reg[i]  <= EDGE_W'(vtx[6+i]) - EDGE_W'(vtx[i]);
                s1_w0_reg[i] <= EDGE_W'(org_reg[i]) - EDGE_W'(vtx[i]);
                s1_p1_reg[i] <= vtx[i];
            end
        end
    end

    // stages 2-4: normal and edge dot products
    logic signed [2*EDGE_W-1:0] prod_n0 [3];
    logic signed [2*EDGE_W-1:0] prod_n1 [3];
    logic signed [2*EDGE_W-1:0] prod_uu [3];
    logic signed [2*EDGE_W-1:0] prod_uv [3];
    logic signed [2*EDGE_W-1:0] prod_vv [3];

    for (genvar g = 0; g < 3; g++) begin : g_nrm
        rti_mul #(.AW(EDGE_W), .BW(EDGE_W)) u_mul_n0 (
            .aclk(aclk), .ce(pipe_ce),
            .a(s1_u_reg[(g+1)%3]), .b(s1_v_reg[(g+2)%3]), .p(prod_n0[g]));
        rti_mul #(.AW(EDGE_W), .BW(EDGE_W)) u_mul_n1 (
            .aclk(aclk), .ce(pipe_ce),
            .a(s1_u_reg[(g+2)%3]), .b(s1_v_reg[(g+1)%3]), .p(prod_n1[g]));
        rti_mul #(.AW(EDGE_W), .BW(EDGE_W)) u_mul_uu (
            .aclk(aclk), .ce(pipe_ce),
            .a(s1_u_reg[g]), .b(s1_u_reg[g]), .p(prod_uu[g]));
        rti_mul #(.AW(EDGE_W), .BW(EDGE_W)) u_mul_uv (
            .aclk(aclk), .ce(pipe_ce),
            .a(s1_u_reg[g]), .b(s1_v_reg[g]), .p(prod_uv[g]));
        rti_mul #(.AW(EDGE_W), .BW(EDGE_W)) u_mul_vv (
            .aclk(aclk), .ce(pipe_ce),
            .a(s1_v_reg[g]), .b(s1_v_reg[g]), .p(prod_vv[g]));
    end

    logic signed [NRM_W-1:0] s4_n_reg [3];
    logic signed [DOT_W-1:0] s4_uu_reg;
    logic signed [DOT_W-1:0] s4_uv_reg;
    logic signed [DOT_W-1:0] s4_vv_reg;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            for (int i = 0; i < 3; i++) begin
                s4_n_reg[i] <= NRM_W'(prod_n0[i]) - NRM_W'(prod_n1[i]);
            end
            s4_uu_reg <= DOT_W'(prod_uu[0]) + DOT_W'(prod_uu[1]) + DOT_W'(prod_uu[2]);
            s4_uv_reg <= DOT_W'(prod_uv[0]) + DOT_W'(prod_uv[1]) + DOT_W'(prod_uv[2]);
            s4_vv_reg <= DOT_W'(prod_vv[0]) + DOT_W'(prod_vv[1]) + DOT_W'(prod_vv[2]);
        end
    end

    logic [3*EDGE_W-1:0] w0_d4;

    rti_delay #(.W(3*EDGE_W), .DEPTH(3)) u_dly_w0 (
        .aclk(aclk), .ce(pipe_ce),
        .d({s1_w0_reg[2], s1_w0_reg[1], s1_w0_reg[0]}), .q(w0_d4));

    // stages 5-7: a = n.w0 and b = n.dir
    logic signed [NRM_W+EDGE_W-1:0] prod_a [3];
    logic signed [NRM_W+DIR_W-1:0]  prod_b [3];

    for (genvar g = 0; g < 3; g++) begin : g_ab
        rti_mul #(.AW(NRM_W), .BW(EDGE_W)) u_mul_a (
            .aclk(aclk), .ce(pipe_ce),
            .a(s4_n_reg[g]), .b(w0_d4[g*EDGE_W +: EDGE_W]), .p(prod_a[g]));
        rti_mul #(.AW(NRM_W), .BW(DIR_W)) u_mul_b (
            .aclk(aclk), .ce(pipe_ce),
            .a(s4_n_reg[g]), .b(dir_reg[g]), .p(prod_b[g]));
    end

    logic s5_deg_reg;
    logic deg_d7;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            s5_deg_reg <= (s4_n_reg[0] == '0) && (s4_n_reg[1] == '0) && (s4_n_reg[2] == '0);
        end
    end

    rti_delay #(.W(1), .DEPTH(2)) u_dly_deg (
        .aclk(aclk), .ce(pipe_ce), .d(s5_deg_reg), .q(deg_d7));

    logic signed [A_W-1:0] s7_a_reg;
    logic signed [B_W-1:0] s7_b_reg;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            s7_a_reg <= A_W'(prod_a[0]) + A_W'(prod_a[1]) + A_W'(prod_a[2]);
            s7_b_reg <= B_W'(prod_b[0]) + B_W'(prod_b[1]) + B_W'(prod_b[2]);
        end
    end

    // stage 8: early-out flags
    logic [B_W-1:0] absb7;
    rti_flags_t     flags7;
    rti_flags_t     s8_flags_reg;

    always_comb begin
        absb7         = s7_b_reg[B_W-1] ? B_W'(-s7_b_reg) : B_W'(s7_b_reg);
        flags7.deg    = deg_d7;
        flags7.par    = (s7_b_reg == '0) || (absb7 < B_W'(tol_reg));
        flags7.azero  = (s7_a_reg == '0);
        flags7.behind = (s7_a_reg != '0) && (s7_b_reg != '0)
                        && (s7_a_reg[A_W-1] == s7_b_reg[B_W-1]);
    end

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            s8_flags_reg <= flags7;
        end
    end

    // stages 8-9: numerator dir_i * (-a)
    logic signed [NEGA_W-1:0]      nega7;
    logic signed [NUM_W-1:0]       prod_num [3];
    logic [B_W-1:0]                b_d9;

    assign nega7 = -(NEGA_W'(s7_a_reg));

    for (genvar g = 0; g < 3; g++) begin : g_num
        rti_mul #(.AW(DIR_W), .BW(NEGA_W)) u_mul_num (
            .aclk(aclk), .ce(pipe_ce),
            .a(dir_reg[g]), .b(nega7), .p(prod_num[g]));
    end

    rti_delay #(.W(B_W), .DEPTH(2)) u_dly_b (
        .aclk(aclk), .ce(pipe_ce), .d(s7_b_reg), .q(b_d9));

    // stage 10: divider operands for round half away from zero
    logic [NUM_W-1:0]  absnum [3];
    logic [B_W-1:0]    absb9;
    logic [DIVN_W-1:0] nsum   [3];
    logic [DIVD_W-1:0] dden;
    logic [DIVN_W-1:0] s10_n_reg [3];
    logic [DIVD_W-1:0] s10_d_reg;
    logic [2:0]        s10_neg_reg;
    logic [2:0]        s10_ovf_reg;

    always_comb begin
        absb9 = b_d9[B_W-1] ? (~b_d9 + 1'b1) : b_d9;
        dden  = DIVD_W'(absb9) << 1;
        for (int i = 0; i < 3; i++) begin
            absnum[i] = prod_num[i][NUM_W-1] ? NUM_W'(-prod_num[i]) : NUM_W'(prod_num[i]);
            nsum[i]   = (DIVN_W'(absnum[i]) << 1) + DIVN_W'(absb9);
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            s10_d_reg <= dden;
            for (int i = 0; i < 3; i++) begin
                s10_n_reg[i]   <= nsum[i];
                s10_neg_reg[i] <= prod_num[i][NUM_W-1] ^ b_d9[B_W-1];
                // quotient too large for any representable point
                s10_ovf_reg[i] <= nsum[i] >= (DIVN_W'(dden) << QUO_W);
            end
        end
    end

    // stages 11-44: dividers
    logic [QUO_W-1:0] quo [3];
    logic [5:0]       sgn_d44;

    for (genvar g = 0; g < 3; g++) begin : g_div
        rti_div #(.NW(DIVN_W), .DW(DIVD_W), .QB(QUO_W)) u_div (
            .aclk(aclk), .ce(pipe_ce),
            .n(s10_n_reg[g]), .d(s10_d_reg), .q(quo[g]));
    end

    rti_delay #(.W(6), .DEPTH(QUO_W)) u_dly_sgn (
        .aclk(aclk), .ce(pipe_ce), .d({s10_ovf_reg, s10_neg_reg}), .q(sgn_d44));

    // stage 45: point = origin + quotient, saturated
    logic signed [SUM_W-1:0]   qs   [3];
    logic signed [SUM_W-1:0]   psum [3];
    logic signed [COORD_W-1:0] pnx  [3];
    logic signed [COORD_W-1:0] s45_p_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qs[i]   = sgn_d44[i] ? -$signed({2'b00, quo[i]}) : $signed({2'b00, quo[i]});
            psum[i] = SUM_W'(org_reg[i]) + qs[i];
            if (sgn_d44[3+i]) begin
                pnx[i] = sgn_d44[i] ? COORD_W'(P_MIN) : COORD_W'(P_MAX);
            end else if (psum[i] > P_MAX) begin
                pnx[i] = COORD_W'(P_MAX);
            end else if (psum[i] < P_MIN) begin
                pnx[i] = COORD_W'(P_MIN);
            end else begin
                pnx[i] = psum[i][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            for (int i = 0; i < 3; i++) begin
                s45_p_reg[i] <= pnx[i];
            end
        end
    end

    // stage 46: w = point - v1
    logic [3*COORD_W-1:0]  p1_d45;
    logic [6*EDGE_W-1:0]   uv_d46;
    logic signed [EDGE_W-1:0] s46_w_reg [3];

    rti_delay #(.W(3*COORD_W), .DEPTH(44)) u_dly_p1 (
        .aclk(aclk), .ce(pipe_ce),
        .d({s1_p1_reg[2], s1_p1_reg[1], s1_p1_reg[0]}), .q(p1_d45));

    rti_delay #(.W(6*EDGE_W), .DEPTH(45)) u_dly_uv (
        .aclk(aclk), .ce(pipe_ce),
        .d({s1_v_reg[2], s1_v_reg[1], s1_v_reg[0],
            s1_u_reg[2], s1_u_reg[1], s1_u_reg[0]}),
        .q(uv_d46));

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            for (int i = 0; i < 3; i++) begin
                s46_w_reg[i] <= EDGE_W'(s45_p_reg[i])
                                - EDGE_W'($signed(p1_d45[i*COORD_W +: COORD_W]));
            end
        end
    end

    // stages 47-49: w.u and w.v
    logic signed [2*EDGE_W-1:0] prod_wu [3];
    logic signed [2*EDGE_W-1:0] prod_wv [3];

    for (genvar g = 0; g < 3; g++) begin : g_wdot
        rti_mul #(.AW(EDGE_W), .BW(EDGE_W)) u_mul_wu (
            .aclk(aclk), .ce(pipe_ce),
            .a(s46_w_reg[g]), .b(uv_d46[g*EDGE_W +: EDGE_W]), .p(prod_wu[g]));
        rti_mul #(.AW(EDGE_W), .BW(EDGE_W)) u_mul_wv (
            .aclk(aclk), .ce(pipe_ce),
            .a(s46_w_reg[g]), .b(uv_d46[(3+g)*EDGE_W +: EDGE_W]), .p(prod_wv[g]));
    end

    logic signed [DOT_W-1:0] s49_wu_reg;
    logic signed [DOT_W-1:0] s49_wv_reg;
    logic [3*DOT_W-1:0]      gram_d49;
    logic signed [DOT_W-1:0] uu49;
    logic signed [DOT_W-1:0] uv49;
    logic signed [DOT_W-1:0] vv49;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            s49_wu_reg <= DOT_W'(prod_wu[0]) + DOT_W'(prod_wu[1]) + DOT_W'(prod_wu[2]);
            s49_wv_reg <= DOT_W'(prod_wv[0]) + DOT_W'(prod_wv[1]) + DOT_W'(prod_wv[2]);
        end
    end

    rti_delay #(.W(3*DOT_W), .DEPTH(45)) u_dly_gram (
        .aclk(aclk), .ce(pipe_ce),
        .d({s4_vv_reg, s4_uv_reg, s4_uu_reg}), .q(gram_d49));

    assign uu49 = gram_d49[0 +: DOT_W];
    assign uv49 = gram_d49[DOT_W +: DOT_W];
    assign vv49 = gram_d49[2*DOT_W +: DOT_W];

    // stages 50-52: parametric numerators and denominator
    logic signed [2*DOT_W-1:0] prod_uvuv;
    logic signed [2*DOT_W-1:0] prod_uuvv;
    logic signed [2*DOT_W-1:0] prod_uvwv;
    logic signed [2*DOT_W-1:0] prod_vvwu;
    logic signed [2*DOT_W-1:0] prod_uvwu;
    logic signed [2*DOT_W-1:0] prod_uuwv;

    rti_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_uvuv (
        .aclk(aclk), .ce(pipe_ce), .a(uv49), .b(uv49), .p(prod_uvuv));
    rti_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_uuvv (
        .aclk(aclk), .ce(pipe_ce), .a(uu49), .b(vv49), .p(prod_uuvv));
    rti_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_uvwv (
        .aclk(aclk), .ce(pipe_ce), .a(uv49), .b(s49_wv_reg), .p(prod_uvwv));
    rti_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_vvwu (
        .aclk(aclk), .ce(pipe_ce), .a(vv49), .b(s49_wu_reg), .p(prod_vvwu));
    rti_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_uvwu (
        .aclk(aclk), .ce(pipe_ce), .a(uv49), .b(s49_wu_reg), .p(prod_uvwu));
    rti_mul #(.AW(DOT_W), .BW(DOT_W)) u_mul_uuwv (
        .aclk(aclk), .ce(pipe_ce), .a(uu49), .b(s49_wv_reg), .p(prod_uuwv));

    logic signed [QUAD_W-1:0] s52_den_reg;
    logic signed [QUAD_W-1:0] s52_ns_reg;
    logic signed [QUAD_W-1:0] s52_nt_reg;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            s52_den_reg <= QUAD_W'(prod_uvuv) - QUAD_W'(prod_uuvv);
            s52_ns_reg  <= QUAD_W'(prod_uvwv) - QUAD_W'(prod_vvwu);
            s52_nt_reg  <= QUAD_W'(prod_uvwu) - QUAD_W'(prod_uuwv);
        end
    end

    // stage 53: inside test, den is negative so the bounds are flipped
    logic                      s53_out_s_reg;
    logic                      s53_out_t_reg;
    logic signed [QUAD_W:0]    s53_st_reg;
    logic signed [QUAD_W:0]    s53_den_reg;

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            s53_out_s_reg <= (s52_ns_reg > 0) || (s52_ns_reg < s52_den_reg);
            s53_out_t_reg <= (s52_nt_reg > 0);
            s53_st_reg    <= (QUAD_W+1)'(s52_ns_reg) + (QUAD_W+1)'(s52_nt_reg);
            s53_den_reg   <= (QUAD_W+1)'(s52_den_reg);
        end
    end

    rti_flags_t           flags53;
    logic [3*COORD_W-1:0] p_d53;

    rti_delay #(.W($bits(rti_flags_t)), .DEPTH(45)) u_dly_flags (
        .aclk(aclk), .ce(pipe_ce), .d(s8_flags_reg), .q(flags53));

    rti_delay #(.W(3*COORD_W), .DEPTH(8)) u_dly_p (
        .aclk(aclk), .ce(pipe_ce),
        .d({s45_p_reg[2], s45_p_reg[1], s45_p_reg[0]}), .q(p_d53));

    rti_result_t res53;
    logic        inside53;

    always_comb begin
        inside53 = !(s53_out_s_reg || s53_out_t_reg || (s53_st_reg < s53_den_reg));
        res53.point_x = p_d53[0 +: COORD_W];
        res53.point_y = p_d53[COORD_W +: COORD_W];
        res53.point_z = p_d53[2*COORD_W +: COORD_W];
        res53.status  = inside53 ? ST_HIT : ST_MISS;
        if (flags53.deg || flags53.par || flags53.behind) begin
            res53.point_x = '0;
            res53.point_y = '0;
            res53.point_z = '0;
        end
        if (flags53.deg) begin
            res53.status = ST_DEGENERATE;
        end else if (flags53.par) begin
            res53.status = flags53.azero ? ST_IN_PLANE : ST_MISS;
        end else if (flags53.behind) begin
            res53.status = ST_MISS;
        end
    end

    rti_result_t out_item;

    rti_skid u_skid (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(vld_reg[PIPE_DEPTH-1]), .in_ready(pipe_ce), .in_item(res53),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_item(out_item));

    assign m_tdata = {out_item.point_z, out_item.point_y, out_item.point_x};
    assign m_tuser = out_item.status;

    `RTI_ASSERT_IMP(a_zero_point,
        m_tvalid && (m_tuser == ST_DEGENERATE || m_tuser == ST_IN_PLANE),
        m_tdata == '0, "nonzero point on degenerate or in-plane result")
    `RTI_ASSERT_IMP(a_stall_needs_output, !s_tready, m_tvalid,
        "pipeline stalled with no result waiting")
    `RTI_ASSERT_NXT(a_stall_freezes_pipe, !s_tready, $stable(vld_reg),
        "pipeline moved during a stall")

endmodule

@@ bench/ray_triangle_intersection_core_test.sv @@
`default_nettype none

module ray_triangle_intersection_core_test import rti_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [31:0] coord_t;

    typedef struct {
        logic [1:0] status;
        coord_t     px;
        coord_t     py;
        coord_t     pz;
    } hit_t;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_PHASES = 12;
    localparam int ITEMS_PER_PHASE = 130;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [287:0]          s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [95:0]           m_tdata;
    logic [1:0]            m_tuser;

    ray_triangle_intersection_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // ray registers as the core should hold them
    coord_t            ray_org [3];
    logic signed [17:0] ray_dir [3];
    logic [15:0]       ray_tol;

    logic [287:0] triangle_queue [$];
    hit_t         expected_hits [$];
    logic         s_fire;
    int           idle_send;
    int           idle_recv;
    int           mismatches;
    int           watchdog;
    int           status_seen [4];
    int           results_seen;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic wide_t wabs(wide_t x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic wide_t round_div(wide_t num, wide_t den);
        wide_t q;
        q = (2 * wabs(num) + wabs(den)) / (2 * wabs(den));
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic wide_t dot3(wide_t x0, wide_t x1, wide_t x2,
                                   wide_t y0, wide_t y1, wide_t y2);
        return x0 * y0 + x1 * y1 + x2 * y2;
    endfunction

    function automatic hit_t intersect_triangle(logic [287:0] tri_bits);
        wide_t  p1 [3];
        wide_t  u [3];
        wide_t  v [3];
        wide_t  w [3];
        wide_t  o [3];
        wide_t  d [3];
        wide_t  n0, n1, n2, a, b, p, uu, uv, vv, wu, wv, den, ns, nt;
        coord_t pt [3];
        hit_t   res;
        for (int i = 0; i < 3; i++) begin
            p1[i] = coord_t'(tri_bits[32*i +: 32]);
            u[i]  = wide_t'(coord_t'(tri_bits[32*(3+i) +: 32])) - p1[i];
            v[i]  = wide_t'(coord_t'(tri_bits[32*(6+i) +: 32])) - p1[i];
            o[i]  = ray_org[i];
            d[i]  = ray_dir[i];
            pt[i] = '0;
        end
        n0 = u[1] * v[2] - u[2] * v[1];
        n1 = u[2] * v[0] - u[0] * v[2];
        n2 = u[0] * v[1] - u[1] * v[0];
        res.status = ST_MISS;
        if (n0 == 0 && n1 == 0 && n2 == 0) begin
            res.status = ST_DEGENERATE;
        end else begin
            a = dot3(n0, n1, n2, o[0] - p1[0], o[1] - p1[1], o[2] - p1[2]);
            b = dot3(n0, n1, n2, d[0], d[1], d[2]);
            if (b == 0 || wabs(b) < wide_t'({1'b0, ray_tol})) begin
                res.status = (a == 0) ? ST_IN_PLANE : ST_MISS;
            end else if (!((a > 0 && b > 0) || (a < 0 && b < 0))) begin
                for (int i = 0; i < 3; i++) begin
                    p = o[i] + round_div(d[i] * (-a), b);
                    if (p > 64'sd2147483647) p = 64'sd2147483647;
                    if (p < -64'sd2147483648) p = -64'sd2147483648;
                    pt[i] = p[31:0];
                    w[i] = wide_t'(pt[i]) - p1[i];
                end
                uu = dot3(u[0], u[1], u[2], u[0], u[1], u[2]);
                uv = dot3(u[0], u[1], u[2], v[0], v[1], v[2]);
                vv = dot3(v[0], v[1], v[2], v[0], v[1], v[2]);
                wu = dot3(w[0], w[1], w[2], u[0], u[1], u[2]);
                wv = dot3(w[0], w[1], w[2], v[0], v[1], v[2]);
                // den is minus the squared normal length, so the bounds flip
                den = uv * uv - uu * vv;
                ns = uv * wv - vv * wu;
                nt = uv * wu - uu * wv;
                if (ns > 0 || ns < den || nt > 0 || ns + nt < den)
                    res.status = ST_MISS;
                else
                    res.status = ST_HIT;
            end
        end
        res.px = pt[0];
        res.py = pt[1];
        res.pz = pt[2];
        return res;
    endfunction

    function automatic coord_t clamp_coord(longint x);
        if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    function automatic logic [287:0] pack_triangle(coord_t c [9]);
        logic [287:0] bits;
        for (int i = 0; i < 9; i++) bits[32*i +: 32] = c[i];
        return bits;
    endfunction

    function automatic coord_t rand_coord();
        return $urandom();
    endfunction

    // triangle around the point at ray step k, with a random spread
    function automatic logic [287:0] triangle_on_ray(longint k);
        coord_t c [9];
        longint spread, center;
        case ($urandom_range(3))
            0: spread = 64'd1 << 10;
            1: spread = 64'd1 << 16;
            2: spread = 64'd1 << 20;
            default: spread = 64'd1 << 26;
        endcase
        for (int j = 0; j < 3; j++) begin
            center = longint'(ray_org[j]) + longint'(ray_dir[j]) * k;
            for (int i = 0; i < 3; i++)
                c[3*i + j] = clamp_coord(center + longint'($urandom_range(2 * spread)) - spread);
        end
        return pack_triangle(c);
    endfunction

    function automatic logic [287:0] random_triangle();
        coord_t c [9];
        logic [287:0] bits;
        int kind;
        longint m;
        kind = $urandom_range(99);
        if (kind < 55) return triangle_on_ray($urandom_range(1, 16384));
        if (kind < 65) return triangle_on_ray(-longint'($urandom_range(1, 16384)));
        bits = triangle_on_ray($urandom_range(0, 16384));
        for (int i = 0; i < 9; i++) c[i] = bits[32*i +: 32];
        if (kind < 75) begin
            // third vertex takes, per coordinate, the first vertex or the first mirrored through the second
            for (int j = 0; j < 3; j++)
                c[6+j] = ($urandom_range(1)) ? c[j] :
                         clamp_coord(2 * longint'(c[3+j]) - longint'(c[j]));
        end else if (kind < 82) begin
            // triangle spanned by the ray itself
            m = $urandom_range(1, 2000);
            for (int j = 0; j < 3; j++) begin
                c[j]   = ray_org[j];
                c[3+j] = clamp_coord(longint'(ray_org[j]) + longint'(ray_dir[j]) * m);
            end
        end else begin
            for (int i = 0; i < 9; i++) c[i] = rand_coord();
        end
        return pack_triangle(c);
    endfunction

    function automatic logic [287:0] unit_triangle(int x1, int y1, int z1, int x2, int y2,
                                                   int z2, int x3, int y3, int z3);
        coord_t c [9];
        c = '{x1 <<< 16, y1 <<< 16, z1 <<< 16, x2 <<< 16, y2 <<< 16, z2 <<< 16,
              x3 <<< 16, y3 <<< 16, z3 <<< 16};
        return pack_triangle(c);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= data;
        case (idx) inside
            CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z: ray_org[idx] = data;
            CFG_DIR_X, CFG_DIR_Y, CFG_DIR_Z: ray_dir[idx - CFG_DIR_X] = data[17:0];
            CFG_TOLERANCE: ray_tol = data[15:0];
            default: ;
        endcase
    endtask

    task automatic setup_ray(int phase);
        int dirs [7][3];
        int pick;
        logic [CFG_DATA_W-1:0] val;
        dirs = '{'{65536, 0, 0}, '{-65536, 0, 0}, '{0, 65536, 0}, '{0, 0, -65536},
                 '{37837, 37837, 37837}, '{46341, -46341, 0}, '{-37837, 37837, -37837}};
        for (int j = 0; j < 3; j++) begin
            if (phase % 4 == 1) val = (j % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else if (phase % 4 == 3) val = $urandom();
            else val = $urandom_range(1 << 25) - (1 << 24);
            write_reg(CFG_IDX_W'(CFG_ORIGIN_X + j), val);
        end
        pick = (phase == 10) ? -1 : phase % 7;
        for (int j = 0; j < 3; j++) begin
            val = $urandom();
            // upper bits past the register width must be dropped
            val[17:0] = (pick < 0) ? 18'($urandom_range(131072) - 65536) : 18'(dirs[pick][j]);
            write_reg(CFG_IDX_W'(CFG_DIR_X + j), val);
        end
        val = $urandom();
        case (phase % 4)
            0: val[15:0] = 16'd0;
            1: val[15:0] = 16'hFFFF;
            2: val[15:0] = 16'd1;
            default: val[15:0] = $urandom_range(65535);
        endcase
        write_reg(CFG_TOLERANCE, val);
        write_reg(CFG_UNUSED, $urandom());
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // driver
    always @(posedge aclk) s_fire <= s_tvalid & s_tready;

    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_fire) begin
                if (s_fire) void'(triangle_queue.pop_front());
                if (triangle_queue.size() > 0 && $urandom_range(99) >= idle_send) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= triangle_queue[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= idle_recv);
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        hit_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) expected_hits.push_back(intersect_triangle(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_hits.size() == 0) begin
                    report_mismatch("unexpected result", {30'd0, m_tuser}, 32'd0);
                end else begin
                    want = expected_hits.pop_front();
                    if (m_tuser != want.status)
                        report_mismatch("status", {30'd0, m_tuser}, {30'd0, want.status});
                    if (m_tdata[31:0] != want.px)
                        report_mismatch("point_x", m_tdata[31:0], want.px);
                    if (m_tdata[63:32] != want.py)
                        report_mismatch("point_y", m_tdata[63:32], want.py);
                    if (m_tdata[95:64] != want.pz)
                        report_mismatch("point_z", m_tdata[95:64], want.pz);
                    status_seen[want.status]++;
                    results_seen++;
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                    (triangle_queue.size() == 0 && expected_hits.size() == 0)) begin
                watchdog <= 0;
            end else if (watchdog >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                watchdog <= watchdog + 1;
            end
        end
    end

    initial begin
        coord_t c [9];
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        aresetn     = 1'b0;
        mismatches  = 0;
        watchdog    = 0;
        results_seen = 0;
        status_seen = '{0, 0, 0, 0};
        idle_send   = 32;
        idle_recv   = 49;
        ray_org     = '{0, 0, 0};
        ray_dir     = '{65536, 0, 0};
        ray_tol     = 16'd1;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part with the ray left at its reset values
        triangle_queue.push_back(unit_triangle(5, -1, -1, 5, 2, -1, 5, -1, 2));
        triangle_queue.push_back(unit_triangle(5, 3, 3, 5, 5, 3, 5, 3, 5));
        triangle_queue.push_back(unit_triangle(-5, -1, -1, -5, 2, -1, -5, -1, 2));
        triangle_queue.push_back(unit_triangle(4, 1, 1, 4, 1, 1, 4, 1, 1));
        triangle_queue.push_back(unit_triangle(1, 1, 1, 2, 2, 2, 3, 3, 3));
        triangle_queue.push_back(unit_triangle(0, 0, 0, 3, 0, 0, 1, 2, 0));
        triangle_queue.push_back(unit_triangle(0, 0, 1, 3, 0, 1, 1, 2, 1));
        triangle_queue.push_back(unit_triangle(0, -1, -1, 0, 2, -1, 0, -1, 2));
        triangle_queue.push_back(unit_triangle(7, 0, 0, 7, 1, 0, 7, 0, 1));
        triangle_queue.push_back(unit_triangle(3, -2, -2, 9, 3, -2, 3, 3, 4));
        for (int i = 0; i < 9; i++) c[i] = 32'h7FFF_FFFF;
        triangle_queue.push_back(pack_triangle(c));
        for (int i = 0; i < 9; i++) c[i] = 32'h8000_0000;
        triangle_queue.push_back(pack_triangle(c));
        c = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
        triangle_queue.push_back(pack_triangle(c));
        c = '{32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
              32'h7FFF_FFFF, 0, 32'h8000_0000};
        triangle_queue.push_back(pack_triangle(c));
        for (int i = 0; i < 6; i++) begin
            for (int j = 0; j < 9; j++) c[j] = ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            triangle_queue.push_back(pack_triangle(c));
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            if (phase >= 8) begin
                idle_send = 0;
                idle_recv = 0;
            end else if (phase >= 4) begin
                idle_send = 49;
                idle_recv = 32;
            end
            if (phase > 0) begin
                wait (triangle_queue.size() == 0 && !s_tvalid && expected_hits.size() == 0);
                repeat (4) @(posedge aclk);
                setup_ray(phase);
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++) triangle_queue.push_back(random_triangle());
        end

        wait (triangle_queue.size() == 0 && !s_tvalid && expected_hits.size() == 0);
        repeat (PIPE_DEPTH * 2) @(posedge aclk);
        $display("checked %0d triangle results over %0d ray settings", results_seen, N_PHASES);
        $display("status counts: miss %0d hit %0d in-plane %0d degenerate %0d",
                 status_seen[ST_MISS], status_seen[ST_HIT], status_seen[ST_IN_PLANE],
                 status_seen[ST_DEGENERATE]);
        if (mismatches == 0 && expected_hits.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
